>>> sv/ipl_pkg.sv
// Shared types and constants for the indexed point list.
`timescale 1ns / 1ps

package ipl_pkg;

  // Default capacity of the list.
  localparam int IPL_DEPTH = 64;

  // Payload widths.
  localparam int KIND_W   = 2;
  localparam int POS_W    = 8;
  localparam int COORD_W  = 16;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  // Operation codes carried in the kind field.
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

  // Position value that means "append at the end".
  localparam logic [POS_W-1:0] POS_APPEND = 8'hFF;

  // Status codes returned with every result.
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Command broadcast to every cell in the row.
  typedef enum logic [2:0] {
    CELL_HOLD = 3'd0,  // no item this cycle, keep everything
    CELL_NONE = 3'd1,  // item taken, no change to entries, clear read tap
    CELL_INS  = 3'd2,  // open a gap at the target and write the new pair
    CELL_REM  = 3'd3,  // close the gap at the target
    CELL_RD   = 3'd4   // capture the entry at the target
  } cell_op_t;

  typedef struct packed {
    cell_op_t                  op;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } cell_cmd_t;

endpackage

>>> sv/ipl_in_if.sv
// Input channel of the indexed point list: valid, ready and one operation.
`timescale 1ns / 1ps

interface ipl_in_if;
  logic                                valid;
  logic                                ready;
  logic        [ipl_pkg::KIND_W-1:0]   kind;
  logic signed [ipl_pkg::POS_W-1:0]    position;
  logic signed [ipl_pkg::COORD_W-1:0]  point_x;
  logic signed [ipl_pkg::COORD_W-1:0]  point_y;

  modport source (output valid, kind, position, point_x, point_y, input ready);
  modport sink   (input valid, kind, position, point_x, point_y, output ready);
endinterface

>>> sv/ipl_out_if.sv
// Result channel of the indexed point list: valid, ready and one result.
`timescale 1ns / 1ps

interface ipl_out_if;
  logic                                valid;
  logic                                ready;
  logic        [ipl_pkg::STATUS_W-1:0] status;
  logic        [ipl_pkg::COUNT_W-1:0]  entry_count;
  logic signed [ipl_pkg::COORD_W-1:0]  read_x;
  logic signed [ipl_pkg::COORD_W-1:0]  read_y;

  modport source (output valid, status, entry_count, read_x, read_y, input ready);
  modport sink   (input valid, status, entry_count, read_x, read_y, output ready);
endinterface

>>> sv/ipl_cell.sv
// One cell of the list: holds one (x, y) entry and trades it with its neighbors.
`timescale 1ns / 1ps

module ipl_cell #(
  parameter int IDX = 0,
  parameter int AT_W = 7
) (
  input  logic                                clk,
  input  ipl_pkg::cell_cmd_t                  cmd,
  input  logic        [AT_W-1:0]              at,
  input  logic signed [ipl_pkg::COORD_W-1:0]  lo_x,
  input  logic signed [ipl_pkg::COORD_W-1:0]  lo_y,
  input  logic signed [ipl_pkg::COORD_W-1:0]  hi_x,
  input  logic signed [ipl_pkg::COORD_W-1:0]  hi_y,
  output logic signed [ipl_pkg::COORD_W-1:0]  ent_x,
  output logic signed [ipl_pkg::COORD_W-1:0]  ent_y,
  output logic signed [ipl_pkg::COORD_W-1:0]  tap_x,
  output logic signed [ipl_pkg::COORD_W-1:0]  tap_y
);

  localparam logic [AT_W-1:0] IDX_W = AT_W'(IDX);

  logic signed [ipl_pkg::COORD_W-1:0] x_r, x_nxt;
  logic signed [ipl_pkg::COORD_W-1:0] y_r, y_nxt;
  logic signed [ipl_pkg::COORD_W-1:0] tx_r, tx_nxt;
  logic signed [ipl_pkg::COORD_W-1:0] ty_r, ty_nxt;
  logic                               hit;

  always_comb begin
    hit    = (IDX_W == at);
    x_nxt  = x_r;
    y_nxt  = y_r;
    tx_nxt = tx_r;
    ty_nxt = ty_r;
    case (cmd.op)
      ipl_pkg::CELL_HOLD: begin
      end
      ipl_pkg::CELL_INS: begin
        // Entries above the target move up; the target takes the new pair.
        if (IDX_W > at) begin
          x_nxt = lo_x;
          y_nxt = lo_y;
        end else if (hit) begin
          x_nxt = cmd.x;
          y_nxt = cmd.y;
        end
        tx_nxt = '0;
        ty_nxt = '0;
      end
      ipl_pkg::CELL_REM: begin
        if (IDX_W >= at) begin
          x_nxt = hi_x;
          y_nxt = hi_y;
        end
        tx_nxt = '0;
        ty_nxt = '0;
      end
      ipl_pkg::CELL_RD: begin
        tx_nxt = hit ? x_r : '0;
        ty_nxt = hit ? y_r : '0;
      end
      default: begin
        tx_nxt = '0;
        ty_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    x_r  <= x_nxt;
    y_r  <= y_nxt;
    tx_r <= tx_nxt;
    ty_r <= ty_nxt;
  end

  assign ent_x = x_r;
  assign ent_y = y_r;
  assign tap_x = tx_r;
  assign tap_y = ty_r;

endmodule

>>> sv/indexed_point_list_unit.sv
// Top level of the indexed point list: decode, row of entry cells and result stage.
`timescale 1ns / 1ps

// Channel   Direction  Payload                                   Handshake
// in_ch     in         kind, position, point_x, point_y           valid / ready
// out_ch    out        status, entry_count, read_x, read_y        valid / ready
//
// Every item produces exactly one result. The row of cells shifts all entries
// in the same cycle, so an item can be accepted on every cycle while the
// output is not stalled; the count compare and the read-tap OR across all
// cells set the two register stages between input and output.
// Reset (rst_n low, synchronous) empties the list and drops items in flight;
// entry contents are not cleared. A stalled output holds its result and the
// middle stage, and the input is taken again as soon as a slot frees up.

module indexed_point_list_unit #(
  parameter int DEPTH = ipl_pkg::IPL_DEPTH
) (
  input logic      clk,
  input logic      rst_n,
  ipl_in_if.sink   in_ch,
  ipl_out_if.source out_ch
);

  // Width of the count (it must hold DEPTH itself) and of position compares.
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int AT_W  = (CNT_W > ipl_pkg::POS_W - 1) ? CNT_W : ipl_pkg::POS_W - 1;

  // Handshake and pipeline control.
  logic take;
  logic out_adv;

  // Entry count of the list.
  logic [CNT_W-1:0] count_r, count_nxt;

  // Decoded operation for this cycle.
  ipl_pkg::cell_cmd_t              cmd;
  logic [AT_W-1:0]                 at;
  logic [ipl_pkg::STATUS_W-1:0]    status;
  logic                            pos_neg;
  logic                            pos_append;
  logic [AT_W-1:0]                 pos_w;
  logic [AT_W-1:0]                 cnt_w;

  // Middle stage: status and count wait here while the cells' read taps settle.
  logic                            s1_valid_r, s1_valid_nxt;
  logic [ipl_pkg::STATUS_W-1:0]    s1_status_r;
  logic [ipl_pkg::COUNT_W-1:0]     s1_count_r;

  // Output register.
  logic                               out_valid_r, out_valid_nxt;
  logic [ipl_pkg::STATUS_W-1:0]       out_status_r;
  logic [ipl_pkg::COUNT_W-1:0]        out_count_r;
  logic signed [ipl_pkg::COORD_W-1:0] out_x_r;
  logic signed [ipl_pkg::COORD_W-1:0] out_y_r;

  // Cell row wiring.
  logic signed [ipl_pkg::COORD_W-1:0] ent_x [DEPTH];
  logic signed [ipl_pkg::COORD_W-1:0] ent_y [DEPTH];
  logic signed [ipl_pkg::COORD_W-1:0] tap_x [DEPTH];
  logic signed [ipl_pkg::COORD_W-1:0] tap_y [DEPTH];
  logic signed [ipl_pkg::COORD_W-1:0] rd_x;
  logic signed [ipl_pkg::COORD_W-1:0] rd_y;

  // The output register frees up when it is empty or being taken this cycle.
  assign out_adv      = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = !s1_valid_r || out_adv;
  assign take         = in_ch.valid && in_ch.ready;

  // Decode: range and capacity checks, target index and the next count.
  always_comb begin
    pos_neg    = in_ch.position[ipl_pkg::POS_W-1];
    pos_append = (in_ch.position == ipl_pkg::POS_APPEND);
    pos_w      = AT_W'(in_ch.position[ipl_pkg::POS_W-2:0]);
    cnt_w      = AT_W'(count_r);
    cmd.op     = ipl_pkg::CELL_NONE;
    cmd.x      = in_ch.point_x;
    cmd.y      = in_ch.point_y;
    at         = pos_w;
    status     = ipl_pkg::ST_DONE;
    count_nxt  = count_r;
    case (in_ch.kind)
      ipl_pkg::KIND_INSERT: begin
        // The position check takes precedence over the full check.
        if ((pos_neg && !pos_append) || (!pos_neg && (pos_w > cnt_w))) begin
          status = ipl_pkg::ST_RANGE;
        end else if (count_r == CNT_W'(DEPTH)) begin
          status = ipl_pkg::ST_FULL;
        end else begin
          cmd.op    = ipl_pkg::CELL_INS;
          at        = pos_append ? cnt_w : pos_w;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      ipl_pkg::KIND_REMOVE: begin
        if (pos_neg || (pos_w >= cnt_w)) begin
          status = ipl_pkg::ST_RANGE;
        end else begin
          cmd.op    = ipl_pkg::CELL_REM;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      ipl_pkg::KIND_READ: begin
        if (pos_neg || (pos_w >= cnt_w)) begin
          status = ipl_pkg::ST_RANGE;
        end else begin
          cmd.op = ipl_pkg::CELL_RD;
        end
      end
      default: begin
        status = ipl_pkg::ST_RANGE;
      end
    endcase
    // Without an accepted item the cells and the count stand still.
    if (!take) begin
      cmd.op    = ipl_pkg::CELL_HOLD;
      count_nxt = count_r;
    end
  end

  // Row of cells. Each cell looks at its lower neighbor for inserts and its
  // upper neighbor for removes; the ends of the row see their own entry.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [ipl_pkg::COORD_W-1:0] lo_x, lo_y, hi_x, hi_y;
    if (i == 0) begin : g_lo_end
      assign lo_x = ent_x[i];
      assign lo_y = ent_y[i];
    end else begin : g_lo
      assign lo_x = ent_x[i-1];
      assign lo_y = ent_y[i-1];
    end
    if (i == DEPTH - 1) begin : g_hi_end
      assign hi_x = ent_x[i];
      assign hi_y = ent_y[i];
    end else begin : g_hi
      assign hi_x = ent_x[i+1];
      assign hi_y = ent_y[i+1];
    end
    ipl_cell #(
      .IDX  (i),
      .AT_W (AT_W)
    ) u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .at    (at),
      .lo_x  (lo_x),
      .lo_y  (lo_y),
      .hi_x  (hi_x),
      .hi_y  (hi_y),
      .ent_x (ent_x[i]),
      .ent_y (ent_y[i]),
      .tap_x (tap_x[i]),
      .tap_y (tap_y[i])
    );
  end

  // At most one cell holds a nonzero read tap, so an OR collects the entry.
  always_comb begin
    rd_x = '0;
    rd_y = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_x = rd_x | tap_x[i];
      rd_y = rd_y | tap_y[i];
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (take) begin
      s1_valid_nxt = 1'b1;
    end else if (out_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_valid_r && out_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_status_r <= status;
      s1_count_r  <= ipl_pkg::COUNT_W'(count_nxt);
    end
    if (s1_valid_r && out_adv) begin
      out_status_r <= s1_status_r;
      out_count_r  <= s1_count_r;
      out_x_r      <= rd_x;
      out_y_r      <= rd_y;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.entry_count = out_count_r;
  assign out_ch.read_x      = out_x_r;
  assign out_ch.read_y      = out_y_r;

endmodule

>>> sv/ipl_checker.sv
// Port-level checks for the indexed point list, bound to the top level.
`timescale 1ns / 1ps

module ipl_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic        [ipl_pkg::STATUS_W-1:0] out_status,
  input logic        [ipl_pkg::COUNT_W-1:0]  out_entry_count,
  input logic signed [ipl_pkg::COORD_W-1:0]  out_read_x,
  input logic signed [ipl_pkg::COORD_W-1:0]  out_read_y
);

  // A result is not withdrawn before it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_status) && $stable(out_entry_count)
      && $stable(out_read_x) && $stable(out_read_y))
    else $error("result payload changed while stalled");

  // A rejected item returns zero coordinates.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ipl_pkg::ST_DONE) |-> (out_read_x == '0) && (out_read_y == '0))
    else $error("rejected item returned coordinates");

  // Reset leaves no result behind.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind indexed_point_list_unit ipl_checker u_ipl_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_entry_count (out_ch.entry_count),
  .out_read_x      (out_ch.read_x),
  .out_read_y      (out_ch.read_y)
);
